[design/dpr_pkg.sv]
// shared types and constants of the depth pixel reprojection block
package dpr_pkg;

  localparam int COL_W   = 12;
  localparam int DEPTH_W = 16;
  localparam int COEF_W  = 32;
  localparam int OPD_W   = COL_W + DEPTH_W;
  localparam int PROD_W  = COEF_W + OPD_W + 1;
  localparam int ACC_W   = 64;
  localparam int DIM_W   = 13;
  localparam int CFG_W   = 64;
  localparam int ADDR_W  = 6;
  localparam int ROWS    = 3;
  localparam int COLS    = 4;

  typedef enum logic [2:0] {
    REG_ROW0_C01 = 3'd0,
    REG_ROW0_C23 = 3'd1,
    REG_ROW1_C01 = 3'd2,
    REG_ROW1_C23 = 3'd3,
    REG_ROW2_C01 = 3'd4,
    REG_ROW2_C23 = 3'd5,
    REG_TGT_W    = 3'd6,
    REG_TGT_H    = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [COL_W-1:0]   src_column;
    logic [COL_W-1:0]   src_row;
    logic [DEPTH_W-1:0] src_depth;
  } in_beat_t;

  typedef struct packed {
    logic [COL_W-1:0]   dst_column;
    logic [COL_W-1:0]   dst_row;
    logic [DEPTH_W-1:0] dst_depth;
  } out_beat_t;

  typedef logic [ROWS-1:0][COLS-1:0][COEF_W-1:0] mat_t;

endpackage

[design/dpr_if.sv]
// valid/ready channels for input pixels and write commands
interface dpr_in_if;
  logic               valid;
  logic               ready;
  dpr_pkg::in_beat_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface dpr_out_if;
  logic               valid;
  logic               ready;
  dpr_pkg::out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[design/dpr_mac.sv]
// operand forming, coefficient products and row sums (three stages)
module dpr_mac (
  input  logic                            clk_i,
  input  logic [2:0]                      ld_i,
  input  dpr_pkg::in_beat_t               beat_i,
  input  dpr_pkg::mat_t                   mat_i,
  output logic signed [dpr_pkg::ACC_W-1:0] x_o,
  output logic signed [dpr_pkg::ACC_W-1:0] y_o,
  output logic signed [dpr_pkg::ACC_W-1:0] z_o
);

  logic [dpr_pkg::OPD_W-1:0]   uz_q, vz_q;
  logic [dpr_pkg::DEPTH_W-1:0] z_q;
  logic signed [dpr_pkg::PROD_W-1:0] prod_q [dpr_pkg::ROWS][3];
  logic signed [dpr_pkg::PROD_W-1:0] prod_d [dpr_pkg::ROWS][3];
  logic signed [dpr_pkg::COEF_W-1:0] off_q [dpr_pkg::ROWS];
  logic signed [dpr_pkg::ACC_W-1:0]  sum_q [dpr_pkg::ROWS];
  logic signed [dpr_pkg::ACC_W-1:0]  sum_d [dpr_pkg::ROWS];
  logic signed [dpr_pkg::OPD_W:0]    opd [3];

  always_ff @(posedge clk_i) begin
    if (ld_i[0]) begin
      uz_q <= dpr_pkg::OPD_W'(beat_i.src_column) * dpr_pkg::OPD_W'(beat_i.src_depth);
      vz_q <= dpr_pkg::OPD_W'(beat_i.src_row) * dpr_pkg::OPD_W'(beat_i.src_depth);
      z_q  <= beat_i.src_depth;
    end
  end

  always_comb begin
    opd[0] = $signed({1'b0, uz_q});
    opd[1] = $signed({1'b0, vz_q});
    opd[2] = $signed({1'b0, dpr_pkg::OPD_W'(z_q)});
    for (int r = 0; r < dpr_pkg::ROWS; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_d[r][c] = dpr_pkg::PROD_W'($signed(mat_i[r][c]))
                       * dpr_pkg::PROD_W'(opd[c]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i[1]) begin
      prod_q <= prod_d;
      for (int r = 0; r < dpr_pkg::ROWS; r++) begin
        off_q[r] <= $signed(mat_i[r][3]);
      end
    end
  end

  always_comb begin
    for (int r = 0; r < dpr_pkg::ROWS; r++) begin
      sum_d[r] = dpr_pkg::ACC_W'(prod_q[r][0]) + dpr_pkg::ACC_W'(prod_q[r][1])
               + dpr_pkg::ACC_W'(prod_q[r][2]) + dpr_pkg::ACC_W'(off_q[r]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i[2]) begin
      sum_q <= sum_d;
    end
  end

  assign x_o = sum_q[0];
  assign y_o = sum_q[1];
  assign z_o = sum_q[2];

endmodule

[design/dpr_div.sv]
// rounding divider for column and row, one quotient bit per stage
module dpr_div #(
  parameter int MAX_DIM   = 4096,
  parameter int FRAC_BITS = 16,
  localparam int QB = $clog2(MAX_DIM),
  localparam int RW = dpr_pkg::ACC_W + QB
) (
  input  logic                             clk_i,
  input  logic [QB:0]                      ld_i,
  input  logic signed [dpr_pkg::ACC_W-1:0] x_i,
  input  logic signed [dpr_pkg::ACC_W-1:0] y_i,
  input  logic signed [dpr_pkg::ACC_W-1:0] z_i,
  output logic                             prep_ok_o,
  output logic [QB-1:0]                    qx_o,
  output logic [QB-1:0]                    qy_o,
  output logic                             negx_o,
  output logic                             negy_o,
  output logic                             ovf_o,
  output logic [dpr_pkg::DEPTH_W-1:0]      dep_o
);

  typedef struct packed {
    logic [RW-1:0]               rx;
    logic [RW-1:0]               ry;
    logic [RW-1:0]               d2;
    logic [QB-1:0]               qx;
    logic [QB-1:0]               qy;
    logic                        nx;
    logic                        ny;
    logic                        ovf;
    logic [dpr_pkg::DEPTH_W-1:0] dep;
  } dstage_t;

  dstage_t st_q [QB+1];
  dstage_t prep_d;

  logic [dpr_pkg::ACC_W-1:0] magx, magy, zu, dsum;
  logic [dpr_pkg::ACC_W-FRAC_BITS-1:0] dsh;

  always_comb begin
    zu   = dpr_pkg::ACC_W'(z_i);
    magx = x_i[dpr_pkg::ACC_W-1] ? (~dpr_pkg::ACC_W'(x_i) + 1'b1) : dpr_pkg::ACC_W'(x_i);
    magy = y_i[dpr_pkg::ACC_W-1] ? (~dpr_pkg::ACC_W'(y_i) + 1'b1) : dpr_pkg::ACC_W'(y_i);
    dsum = zu + (dpr_pkg::ACC_W'(1) << (FRAC_BITS - 1));
    dsh  = dsum[dpr_pkg::ACC_W-1:FRAC_BITS];
    prep_d.rx  = RW'({magx[dpr_pkg::ACC_W-2:0], 1'b0}) + RW'(zu);
    prep_d.ry  = RW'({magy[dpr_pkg::ACC_W-2:0], 1'b0}) + RW'(zu);
    prep_d.d2  = RW'({zu[dpr_pkg::ACC_W-2:0], 1'b0});
    prep_d.qx  = '0;
    prep_d.qy  = '0;
    prep_d.nx  = x_i[dpr_pkg::ACC_W-1];
    prep_d.ny  = y_i[dpr_pkg::ACC_W-1];
    prep_d.ovf = 1'b0;
    prep_d.dep = (dsh > (dpr_pkg::ACC_W-FRAC_BITS)'({dpr_pkg::DEPTH_W{1'b1}}))
                 ? {dpr_pkg::DEPTH_W{1'b1}} : dpr_pkg::DEPTH_W'(dsh);
  end

  // item drops here when the third coordinate is not positive
  assign prep_ok_o = (z_i > 0);

  always_ff @(posedge clk_i) begin
    if (ld_i[0]) begin
      st_q[0] <= prep_d;
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_step
    localparam int S = QB - 1 - j;
    dstage_t nx_d;
    logic [RW-1:0] dsh_s;
    logic bx, by;
    always_comb begin
      nx_d  = st_q[j];
      dsh_s = st_q[j].d2 << S;
      bx    = (st_q[j].rx >= dsh_s);
      by    = (st_q[j].ry >= dsh_s);
      if (bx) begin
        nx_d.rx = st_q[j].rx - dsh_s;
      end
      if (by) begin
        nx_d.ry = st_q[j].ry - dsh_s;
      end
      nx_d.qx[S] = bx;
      nx_d.qy[S] = by;
      if (j == 0) begin
        // quotient beyond the divider range
        nx_d.ovf = (st_q[j].rx >= (st_q[j].d2 << QB)) || (st_q[j].ry >= (st_q[j].d2 << QB));
      end
    end
    always_ff @(posedge clk_i) begin
      if (ld_i[j+1]) begin
        st_q[j+1] <= nx_d;
      end
    end
  end

  assign qx_o   = st_q[QB].qx;
  assign qy_o   = st_q[QB].qy;
  assign negx_o = st_q[QB].nx;
  assign negy_o = st_q[QB].ny;
  assign ovf_o  = st_q[QB].ovf;
  assign dep_o  = st_q[QB].dep;

endmodule

[design/depth_pixel_reprojection.sv]
// top level: pixel reprojection pipeline, register file and output stage
// stages: operand forming, products, row sums, divider prep, one per quotient bit, output
// one pixel per cycle if not stalled; column/row divider retires one quotient bit per stage
// a full stage holds only if every later stage is full; empty stages fill, bubbles close up
// reset clears all valid bits and loads the identity matrix and a 640x480 output size
module depth_pixel_reprojection #(
  parameter int MAX_DIM   = 4096,
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  dpr_in_if.sink                      in_s,
  dpr_out_if.source                   out_s,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dpr_pkg::ADDR_W-1:0]  paddr,
  input  logic [dpr_pkg::CFG_W-1:0]   pwdata,
  output logic [dpr_pkg::CFG_W-1:0]   prdata,
  output logic                        pready
);

  localparam int QB = $clog2(MAX_DIM);
  localparam int NS = 5 + QB;
  localparam logic [dpr_pkg::CFG_W-1:0] ONE_FX = dpr_pkg::CFG_W'(1) << FRAC_BITS;

  logic [dpr_pkg::CFG_W-1:0] coef_q [6];
  logic [dpr_pkg::DIM_W-1:0] tw_q, th_q;
  dpr_pkg::reg_idx_e         widx;
  dpr_pkg::mat_t             mat;

  logic [NS-1:0] vld_q, ld, pass;
  logic signed [dpr_pkg::ACC_W-1:0] x, y, z;
  logic          prep_ok, negx, negy, ovf, fin_ok;
  logic [QB-1:0] qx, qy;
  logic [dpr_pkg::DEPTH_W-1:0] dep;
  logic [31:0]   lim_w, lim_h;
  dpr_pkg::out_beat_t out_q;

  // configuration
  assign pready = 1'b1;
  assign widx   = dpr_pkg::reg_idx_e'(paddr[dpr_pkg::ADDR_W-1:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q[0] <= ONE_FX;
      coef_q[1] <= '0;
      coef_q[2] <= ONE_FX << 32;
      coef_q[3] <= '0;
      coef_q[4] <= '0;
      coef_q[5] <= ONE_FX;
      tw_q      <= dpr_pkg::DIM_W'(640);
      th_q      <= dpr_pkg::DIM_W'(480);
    end else if (psel && penable && pwrite) begin
      unique case (widx)
        dpr_pkg::REG_ROW0_C01: coef_q[0] <= pwdata;
        dpr_pkg::REG_ROW0_C23: coef_q[1] <= pwdata;
        dpr_pkg::REG_ROW1_C01: coef_q[2] <= pwdata;
        dpr_pkg::REG_ROW1_C23: coef_q[3] <= pwdata;
        dpr_pkg::REG_ROW2_C01: coef_q[4] <= pwdata;
        dpr_pkg::REG_ROW2_C23: coef_q[5] <= pwdata;
        dpr_pkg::REG_TGT_W:    tw_q <= pwdata[dpr_pkg::DIM_W-1:0];
        dpr_pkg::REG_TGT_H:    th_q <= pwdata[dpr_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      dpr_pkg::REG_ROW0_C01: prdata = coef_q[0];
      dpr_pkg::REG_ROW0_C23: prdata = coef_q[1];
      dpr_pkg::REG_ROW1_C01: prdata = coef_q[2];
      dpr_pkg::REG_ROW1_C23: prdata = coef_q[3];
      dpr_pkg::REG_ROW2_C01: prdata = coef_q[4];
      dpr_pkg::REG_ROW2_C23: prdata = coef_q[5];
      dpr_pkg::REG_TGT_W:    prdata = dpr_pkg::CFG_W'(tw_q);
      dpr_pkg::REG_TGT_H:    prdata = dpr_pkg::CFG_W'(th_q);
      default:               prdata = '0;
    endcase
  end

  always_comb begin
    for (int r = 0; r < dpr_pkg::ROWS; r++) begin
      mat[r][0] = coef_q[2*r][31:0];
      mat[r][1] = coef_q[2*r][63:32];
      mat[r][2] = coef_q[2*r+1][31:0];
      mat[r][3] = coef_q[2*r+1][63:32];
    end
  end

  // pipeline control: a stage loads when it is empty or its beat moves on
  always_comb begin
    ld[NS-1] = !vld_q[NS-1] || out_s.ready;
    for (int k = NS-2; k >= 0; k--) begin
      ld[k] = !vld_q[k] || ld[k+1];
    end
  end

  always_comb begin
    pass       = '1;
    pass[0]    = (in_s.data.src_depth != '0)
                 && (32'(in_s.data.src_column) < MAX_DIM)
                 && (32'(in_s.data.src_row) < MAX_DIM);
    pass[3]    = prep_ok;
    pass[NS-1] = fin_ok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (ld[0]) begin
        vld_q[0] <= in_s.valid && pass[0];
      end
      for (int k = 1; k < NS; k++) begin
        if (ld[k]) begin
          vld_q[k] <= vld_q[k-1] && pass[k];
        end
      end
    end
  end

  assign in_s.ready = ld[0];

  dpr_mac u_mac (
    .clk_i  (clk_i),
    .ld_i   (ld[2:0]),
    .beat_i (in_s.data),
    .mat_i  (mat),
    .x_o    (x),
    .y_o    (y),
    .z_o    (z)
  );

  dpr_div #(
    .MAX_DIM   (MAX_DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i     (clk_i),
    .ld_i      (ld[3+QB:3]),
    .x_i       (x),
    .y_i       (y),
    .z_i       (z),
    .prep_ok_o (prep_ok),
    .qx_o      (qx),
    .qy_o      (qy),
    .negx_o    (negx),
    .negy_o    (negy),
    .ovf_o     (ovf),
    .dep_o     (dep)
  );

  // output window and divider overflow check
  always_comb begin
    lim_w  = (32'(tw_q) > MAX_DIM) ? 32'(MAX_DIM) : 32'(tw_q);
    lim_h  = (32'(th_q) > MAX_DIM) ? 32'(MAX_DIM) : 32'(th_q);
    fin_ok = !ovf && !(negx && (qx != '0)) && !(negy && (qy != '0))
             && (32'(qx) < lim_w) && (32'(qy) < lim_h);
  end

  always_ff @(posedge clk_i) begin
    if (ld[NS-1]) begin
      out_q.dst_column <= dpr_pkg::COL_W'(qx);
      out_q.dst_row    <= dpr_pkg::COL_W'(qy);
      out_q.dst_depth  <= dep;
    end
  end

  assign out_s.valid = vld_q[NS-1];
  assign out_s.data  = out_q;

  a_zero_depth_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_s.valid && in_s.ready && (in_s.data.src_depth == '0)) |=> !vld_q[0])
    else $error("zero depth pixel entered the pipeline");

  a_stall_holds_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[NS-2] && !ld[NS-1]) |=> vld_q[NS-2])
    else $error("beat lost while the output stage was stalled");

  a_stage_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[3] && ld[4]) |=> vld_q[4])
    else $error("beat lost inside the divider");

endmodule
